[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[hw/rtl/lzwte_pkg.sv]
// Types and constants of the LZW trie encoder.
`default_nettype none
package lzwte_pkg;

    localparam int LIMIT_W     = 13;
    localparam int LIMIT_RESET = 4096;
    localparam int EOS_CODE    = 256;
    localparam int FIRST_FREE  = 257;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    typedef struct packed {
        logic       eos;
        logic [7:0] sym;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHILD,
        S_SIB,
        S_MISS,
        S_LINK,
        S_EMIT_PHR,
        S_EMIT_EOS
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/lzw_trie_encoder.sv]
// LZW trie encoder: input queue in front of a trie-walking code engine.
// A taken transfer is written into the input queue before the engine sees it; the engine takes
//   one byte at a time. A byte opening a phrase is taken in S_IDLE; a hit walks S_CHILD, then
//   S_SIB over up to 256 sibling entries; a miss ends in S_MISS, then S_LINK to add a phrase.
//   A miss and each end-of-stream code (1 or 2 codes, one per cycle) hold while output is full.
// Reset: synchronous, active low; clearing the first 256 child links keeps s_tready low.
`default_nettype none
module lzw_trie_encoder #(
    parameter int CODE_BITS    = 12,
    parameter int DICT_ENTRIES = 4096
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lzwte_pkg::LIMIT_W-1:0]      cfg_data,   // [12:0] dictionary_limit
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,    // [7:0] data_byte
    input  wire logic                               s_tuser,    // [0] func
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [((CODE_BITS+7)/8)*8-1:0]          m_tdata,    // [CODE_BITS-1:0] code
    output logic                                    m_tlast
);
    import lzwte_pkg::*;

    queue_out_t q_out;
    logic       q_pop;
    logic       init_done;

    lzwte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_done (init_done),
        .q_out     (q_out),
        .q_pop     (q_pop)
    );

    lzwte_back #(
        .CODE_BITS    (CODE_BITS),
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_out     (q_out),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

[hw/rtl/lzwte_front.sv]
// Input stage: accepts stream items, classifies them and queues them for the engine.
`default_nettype none
`include "assert_macros.svh"
module lzwte_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
    input  wire logic                s_tuser,   // [0] func
    input  wire logic                init_done,
    output lzwte_pkg::queue_out_t    q_out,
    input  wire logic                q_pop
);
    import lzwte_pkg::*;

    item_t               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic                push;
    item_t               in_item;

    assign s_tready    = init_done && (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push        = s_tvalid && s_tready;
    assign in_item.eos = s_tuser;
    assign in_item.sym = s_tdata;

    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `ASSERT_AT(a_no_input_before_init, aclk, aresetn, !init_done |-> !s_tready)
    `ASSERT_NEVER(a_no_pop_when_empty, aclk, aresetn, q_pop && (count_reg == '0))
    `ASSERT_AT(a_count_up_on_push, aclk, aresetn, (push && !q_pop) |=> (count_reg == $past(count_reg) + Q_CNT_W'(1)))

endmodule
`default_nettype wire

[hw/rtl/lzwte_back.sv]
// Trie engine: walks child and sibling links, emits codes and appends phrases.
`default_nettype none
`include "assert_macros.svh"
module lzwte_back #(
    parameter int CODE_BITS    = 12,
    parameter int DICT_ENTRIES = 4096
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lzwte_pkg::LIMIT_W-1:0]        cfg_data,
    input  wire lzwte_pkg::queue_out_t                q_out,
    output logic                                      q_pop,
    output logic                                      init_done,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((CODE_BITS+7)/8)*8-1:0]            m_tdata,
    output logic                                      m_tlast
);
    import lzwte_pkg::*;

    localparam int IDX_W = $clog2(DICT_ENTRIES);
    localparam int NF_W  = IDX_W + 1;
    localparam int CMP_W = (NF_W > LIMIT_W) ? NF_W : LIMIT_W;
    localparam int OUT_W = ((CODE_BITS + 7) / 8) * 8;
    localparam int SIB_W = IDX_W + 8;

    state_t               state_reg, state_next;
    logic [7:0]           clr_cnt_reg;
    logic [IDX_W-1:0]     current_reg;
    logic                 pending_reg;
    logic [NF_W-1:0]      nf_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [7:0]           sym_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     walk_reg;
    logic                 out_valid_reg;
    logic [CODE_BITS-1:0] out_code_reg;
    logic                 out_last_reg;

    logic [IDX_W-1:0]     child_mem [DICT_ENTRIES];
    logic [SIB_W-1:0]     sib_mem   [DICT_ENTRIES];
    logic [IDX_W-1:0]     child_rdata_reg;
    logic [SIB_W-1:0]     sib_rdata_reg;

    logic                 child_we, child_re, sib_we, sib_re;
    logic [IDX_W-1:0]     child_waddr, child_wdata, child_raddr;
    logic [IDX_W-1:0]     sib_waddr, sib_raddr;
    logic [SIB_W-1:0]     sib_wdata;

    logic                 out_free, out_load, out_last;
    logic [CODE_BITS-1:0] out_code, cur_code;
    logic                 add_ok, sib_match, sib_end, child_null;
    logic [IDX_W-1:0]     sib_next;
    logic [IDX_W-1:0]     nf_idx;
    logic [IDX_W-1:0]     sym_idx;

    assign cfg_ready  = 1'b1;
    assign init_done  = (state_reg != S_CLEAR);
    assign out_free   = !out_valid_reg || m_tready;
    assign cur_code   = CODE_BITS'(current_reg);
    assign nf_idx     = nf_reg[IDX_W-1:0];
    assign sym_idx    = IDX_W'(sym_reg);
    assign sib_next   = sib_rdata_reg[SIB_W-1:8];
    assign sib_match  = (sib_rdata_reg[7:0] == sym_reg);
    assign sib_end    = (sib_next == '0);
    assign child_null = (child_rdata_reg == '0);
    assign add_ok     = (CMP_W'(nf_reg) < CMP_W'(limit_reg))
                     && (nf_reg < NF_W'(DICT_ENTRIES));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_code_reg);
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == 8'hFF) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_out.valid) begin
                    if (q_out.item.eos) begin
                        state_next = pending_reg ? S_EMIT_PHR : S_EMIT_EOS;
                    end else if (pending_reg) begin
                        state_next = S_CHILD;
                    end
                end
            end
            S_CHILD: begin
                state_next = child_null ? S_MISS : S_SIB;
            end
            S_SIB: begin
                if (sib_match) begin
                    state_next = S_IDLE;
                end else if (sib_end) begin
                    state_next = S_MISS;
                end
            end
            S_MISS: begin
                if (out_free) begin
                    state_next = add_ok ? S_LINK : S_IDLE;
                end
            end
            S_LINK: begin
                state_next = S_IDLE;
            end
            S_EMIT_PHR: begin
                if (out_free) begin
                    state_next = S_EMIT_EOS;
                end
            end
            S_EMIT_EOS: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop       = 1'b0;
        child_we    = 1'b0;
        child_waddr = '0;
        child_wdata = '0;
        child_re    = 1'b0;
        child_raddr = current_reg;
        sib_we      = 1'b0;
        sib_waddr   = nf_idx;
        sib_wdata   = {head_reg, sym_reg};
        sib_re      = 1'b0;
        sib_raddr   = child_rdata_reg;
        out_load    = 1'b0;
        out_code    = cur_code;
        out_last    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = IDX_W'(clr_cnt_reg);
            end
            S_IDLE: begin
                q_pop    = q_out.valid;
                child_re = q_out.valid && !q_out.item.eos && pending_reg;
            end
            S_CHILD: begin
                sib_re    = !child_null;
                sib_raddr = child_rdata_reg;
            end
            S_SIB: begin
                sib_re    = !sib_match && !sib_end;
                sib_raddr = sib_next;
            end
            S_MISS: begin
                out_load    = out_free;
                sib_we      = out_free && add_ok;
                child_we    = out_free && add_ok;
                child_waddr = nf_idx;
            end
            S_LINK: begin
                child_we    = 1'b1;
                child_waddr = current_reg;
                child_wdata = nf_idx;
            end
            S_EMIT_PHR: begin
                out_load = out_free;
            end
            S_EMIT_EOS: begin
                out_load = out_free;
                out_code = CODE_BITS'(EOS_CODE);
                out_last = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            current_reg   <= '0;
            pending_reg   <= 1'b0;
            nf_reg        <= NF_W'(FIRST_FREE);
            limit_reg     <= LIMIT_W'(LIMIT_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 8'd1;
                end
                S_IDLE: begin
                    if (q_out.valid && !q_out.item.eos && !pending_reg) begin
                        current_reg <= IDX_W'(q_out.item.sym);
                        pending_reg <= 1'b1;
                    end
                end
                S_SIB: begin
                    if (sib_match) begin
                        current_reg <= walk_reg;
                    end
                end
                S_MISS: begin
                    if (out_free && !add_ok) begin
                        current_reg <= sym_idx;
                    end
                end
                S_LINK: begin
                    current_reg <= sym_idx;
                    nf_reg      <= nf_reg + NF_W'(1);
                end
                S_EMIT_EOS: begin
                    if (out_free) begin
                        current_reg <= '0;
                        pending_reg <= 1'b0;
                    end
                end
                default: begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && q_out.valid) begin
            sym_reg <= q_out.item.sym;
        end
        if (state_reg == S_CHILD) begin
            head_reg <= child_rdata_reg;
            walk_reg <= child_rdata_reg;
        end else if (state_reg == S_SIB) begin
            walk_reg <= sib_next;
        end
        if (out_load) begin
            out_code_reg <= out_code;
            out_last_reg <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (child_re) begin
            child_rdata_reg <= child_mem[child_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sib_we) begin
            sib_mem[sib_waddr] <= sib_wdata;
        end
        if (sib_re) begin
            sib_rdata_reg <= sib_mem[sib_raddr];
        end
    end

    `ASSERT_NEVER(a_no_pop_while_clearing, aclk, aresetn, (state_reg == S_CLEAR) && q_pop)
    `ASSERT_AT(a_free_code_grows_on_link, aclk, aresetn, (state_reg == S_LINK) |=> (nf_reg == $past(nf_reg) + NF_W'(1)))
    `ASSERT_AT(a_free_code_held_elsewhere, aclk, aresetn, (state_reg != S_LINK) |=> $stable(nf_reg))
    `ASSERT_NEVER(a_emit_only_with_room, aclk, aresetn, out_load && out_valid_reg && !m_tready)

endmodule
`default_nettype wire
